// ----- hdl/assert_macros.svh -----
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hdl/qcr_pkg.sv -----
package qcr_pkg;

  localparam int INPUT_DEPTH_DEF    = 65536;
  localparam int WEIGHT_DEPTH_DEF   = 65536;
  localparam int MAX_CHANNELS_DEF   = 1024;
  localparam int MULT_FRAC_BITS_DEF = 40;

  localparam int ADDR_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int BIAS_W     = 64;
  localparam int ACC_W      = 32;

  typedef enum logic [1:0] {
    MODE_PIXEL   = 2'd0,
    MODE_WEIGHT  = 2'd1,
    MODE_BIAS    = 2'd2,
    MODE_COMPUTE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_IN_CH  = 3'd0,
    REG_OUT_CH = 3'd1,
    REG_HEIGHT = 3'd2,
    REG_WIDTH  = 3'd3,
    REG_KERNEL = 3'd4,
    REG_STRIDE = 3'd5,
    REG_ZP     = 3'd6,
    REG_MULT   = 3'd7
  } reg_idx_t;

  // read strobes from the sequencer to the stores
  typedef struct packed {
    logic pix_en;
    logic wt_en;
    logic bias_en;
  } rd_req_t;

endpackage

// ----- hdl/qcr_stream_if.sv -----
interface qcr_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [15:0]       address;
  logic [7:0]        pixel_value;
  logic signed [7:0] weight_value;
  logic signed [63:0] bias_value;

  modport source (output valid, mode, address, pixel_value, weight_value, bias_value,
                  input ready);
  modport sink (input valid, mode, address, pixel_value, weight_value, bias_value,
                output ready);
endinterface

interface qcr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_pixel;
  logic       index_error;

  modport source (output valid, out_pixel, index_error, input ready);
  modport sink (input valid, out_pixel, index_error, output ready);
endinterface

// ----- hdl/qcr_div.sv -----
module qcr_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quot,
  output logic [15:0] rem
);
  import qcr_pkg::*;

  // restoring division, one quotient bit per cycle
  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [15:0] q_r;
  logic [16:0] rem_r;
  logic [15:0] dvs_r;
  logic [16:0] trial;
  logic [16:0] diff;

  assign trial = {rem_r[15:0], q_r[15]};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (!diff[16]) begin
        rem_r <= diff;
        q_r   <= {q_r[14:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r   <= {q_r[14:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r[15:0];

endmodule

// ----- hdl/qcr_store.sv -----
module qcr_store #(
  parameter int INPUT_DEPTH  = qcr_pkg::INPUT_DEPTH_DEF,
  parameter int WEIGHT_DEPTH = qcr_pkg::WEIGHT_DEPTH_DEF,
  parameter int MAX_CHANNELS = qcr_pkg::MAX_CHANNELS_DEF
) (
  input  logic                     clk,
  input  logic                     ld_en,
  input  logic [1:0]               ld_mode,
  input  logic [qcr_pkg::ADDR_W-1:0] ld_addr,
  input  logic [7:0]               ld_pixel,
  input  logic [7:0]               ld_weight,
  input  logic [qcr_pkg::BIAS_W-1:0] ld_bias,
  input  qcr_pkg::rd_req_t         rd,
  input  logic [31:0]              pix_rd_addr,
  input  logic [31:0]              wt_rd_addr,
  input  logic [31:0]              bias_rd_addr,
  output logic [7:0]               pix_rd_data,
  output logic [7:0]               wt_rd_data,
  output logic [qcr_pkg::BIAS_W-1:0] bias_rd_data
);
  import qcr_pkg::*;

  localparam int IAW = (INPUT_DEPTH  > 1) ? $clog2(INPUT_DEPTH)  : 1;
  localparam int WAW = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
  localparam int BAW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [7:0]        pix_mem  [INPUT_DEPTH];
  logic [7:0]        wt_mem   [WEIGHT_DEPTH];
  logic [BIAS_W-1:0] bias_mem [MAX_CHANNELS];

  logic [31:0] ld_addr32;
  logic        pix_we;
  logic        wt_we;
  logic        bias_we;

  assign ld_addr32 = 32'(ld_addr);
  // loads beyond a store are dropped
  assign pix_we  = ld_en && (mode_t'(ld_mode) == MODE_PIXEL)  && (ld_addr32 < 32'(INPUT_DEPTH));
  assign wt_we   = ld_en && (mode_t'(ld_mode) == MODE_WEIGHT) && (ld_addr32 < 32'(WEIGHT_DEPTH));
  assign bias_we = ld_en && (mode_t'(ld_mode) == MODE_BIAS)   && (ld_addr32 < 32'(MAX_CHANNELS));

  always_ff @(posedge clk) begin
    if (pix_we) begin
      pix_mem[ld_addr32[IAW-1:0]] <= ld_pixel;
    end
    if (rd.pix_en) begin
      pix_rd_data <= pix_mem[pix_rd_addr[IAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wt_we) begin
      wt_mem[ld_addr32[WAW-1:0]] <= ld_weight;
    end
    if (rd.wt_en) begin
      wt_rd_data <= wt_mem[wt_rd_addr[WAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (bias_we) begin
      bias_mem[ld_addr32[BAW-1:0]] <= ld_bias;
    end
    if (rd.bias_en) begin
      bias_rd_data <= bias_mem[bias_rd_addr[BAW-1:0]];
    end
  end

endmodule

// ----- hdl/qcr_requant.sv -----
module qcr_requant #(
  parameter int MULT_FRAC_BITS = qcr_pkg::MULT_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [qcr_pkg::ACC_W-1:0]    acc,
  input  logic signed [qcr_pkg::BIAS_W-1:0] bias,
  input  logic [qcr_pkg::CFG_DATA_W-1:0] mult,
  input  logic [7:0]                   zout,
  output logic                         done,
  output logic [7:0]                   pixel
);
  import qcr_pkg::*;

  localparam int VW = 82;
  localparam logic [VW-1:0] HALF = VW'(1) << (MULT_FRAC_BITS - 1);

  typedef enum logic [8:0] {
    R_IDLE = 9'b000000001,
    R_MUL0 = 9'b000000010,
    R_MUL1 = 9'b000000100,
    R_SUM  = 9'b000001000,
    R_SIGN = 9'b000010000,
    R_BIAS = 9'b000100000,
    R_ABS  = 9'b001000000,
    R_RND  = 9'b010000000,
    R_FIN  = 9'b100000000
  } rq_state_t;

  rq_state_t state_r;
  logic      done_r;

  logic                     neg_r;
  logic [31:0]              mag_r;
  logic signed [BIAS_W-1:0] bias_r;
  logic [47:0]              mult_r;
  logic [7:0]               zout_r;
  logic [55:0]              plo_r;
  logic [55:0]              phi_r;
  logic signed [VW-1:0]     v_r;
  logic [VW-1:0]            a_r;
  logic                     vneg_r;
  logic [10:0]              rq_r;
  logic [7:0]               pix_r;

  logic [23:0]   mul_b;
  logic [55:0]   mul_p;
  logic [VW-1:0] rnd_sum;
  logic [VW-1:0] rnd_sh;
  logic signed [12:0] sval;
  logic signed [12:0] oval;

  // one 32x24 multiplier, used for the low and high halves of the multiplier
  assign mul_b = (state_r == R_MUL0) ? mult_r[23:0] : mult_r[47:24];
  assign mul_p = 56'(mag_r) * 56'(mul_b);

  assign rnd_sum = a_r + HALF;
  assign rnd_sh  = rnd_sum >> MULT_FRAC_BITS;
  assign sval    = vneg_r ? -$signed(13'(rq_r)) : $signed(13'(rq_r));
  assign oval    = sval + $signed(13'(zout_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        R_IDLE: if (start) state_r <= R_MUL0;
        R_MUL0: state_r <= R_MUL1;
        R_MUL1: state_r <= R_SUM;
        R_SUM:  state_r <= R_SIGN;
        R_SIGN: state_r <= R_BIAS;
        R_BIAS: state_r <= R_ABS;
        R_ABS:  state_r <= R_RND;
        R_RND:  state_r <= R_FIN;
        R_FIN: begin
          state_r <= R_IDLE;
          done_r  <= 1'b1;
        end
        default: state_r <= R_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      R_IDLE: begin
        if (start) begin
          neg_r  <= acc[31];
          mag_r  <= acc[31] ? 32'(33'h1_0000_0000 - 33'(acc)) : acc;
          bias_r <= bias;
          mult_r <= mult;
          zout_r <= zout;
        end
      end
      R_MUL0: plo_r <= mul_p;
      R_MUL1: phi_r <= mul_p;
      R_SUM:  v_r   <= $signed(VW'({phi_r, 24'b0}) + VW'(plo_r));
      R_SIGN: if (neg_r) v_r <= -v_r;
      R_BIAS: v_r <= v_r + VW'(bias_r);
      R_ABS: begin
        vneg_r <= v_r[VW-1];
        a_r    <= v_r[VW-1] ? VW'(-v_r) : VW'(v_r);
      end
      // magnitude saturates at 1024 before the output clamp
      R_RND: rq_r <= (rnd_sh > VW'(1024)) ? 11'd1024 : rnd_sh[10:0];
      R_FIN: begin
        if (oval > 13'sd255) begin
          pix_r <= 8'd255;
        end else if (oval < 13'sd0) begin
          pix_r <= 8'd0;
        end else begin
          pix_r <= oval[7:0];
        end
      end
      default: ;
    endcase
  end

  assign done  = done_r;
  assign pixel = pix_r;

endmodule

// ----- hdl/quantized_conv2d_requant_top.sv -----
// channel   dir  handshake        payload
// in_ch     in   valid/ready      mode, address, pixel_value, weight_value, bias_value
// out_ch    out  valid/ready      out_pixel, index_error
// cfg_*     in   cfg_we only      cfg_index, cfg_data (48 bits, no read-back)
//
// a load transfer writes one store entry, unless its address lies beyond that store
// a compute item runs four divisions for geometry and index decode, then one kernel tap
//   per cycle out of the pixel and weight memories, a two-stage multiply/accumulate drain
//   and the requantizer before its result is valid
// an out-of-range index returns after the geometry phase
// reset is synchronous, active low; stores hold no reset state
// a finished result waits in the output register; loads keep flowing meanwhile, and a
//   second compute waits for that register to free before it writes
module quantized_conv2d_requant_top #(
  parameter int INPUT_DEPTH    = qcr_pkg::INPUT_DEPTH_DEF,
  parameter int WEIGHT_DEPTH   = qcr_pkg::WEIGHT_DEPTH_DEF,
  parameter int MAX_CHANNELS   = qcr_pkg::MAX_CHANNELS_DEF,
  parameter int MULT_FRAC_BITS = qcr_pkg::MULT_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  qcr_in_if.sink                          in_ch,
  qcr_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [qcr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [qcr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import qcr_pkg::*;
  `include "assert_macros.svh"

  // sequencer states
  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_GEOM  = 14'b00000000000010,
    S_DIVH  = 14'b00000000000100,
    S_DIVW  = 14'b00000000001000,
    S_TOT1  = 14'b00000000010000,
    S_TOT2  = 14'b00000000100000,
    S_CHK   = 14'b00000001000000,
    S_DIV1  = 14'b00000010000000,
    S_DIV2  = 14'b00000100000000,
    S_PRE1  = 14'b00001000000000,
    S_PRE2  = 14'b00010000000000,
    S_MAC   = 14'b00100000000000,
    S_DRAIN = 14'b01000000000000,
    S_RQ    = 14'b10000000000000
  } seq_state_t;

  // output staging uses its own flag beside the sequencer state; while it is set the idle state takes no input
  logic out_pend_r;

  seq_state_t state_r;

  // configuration registers
  logic [10:0] cfg_in_ch_r;
  logic [10:0] cfg_out_ch_r;
  logic [8:0]  cfg_height_r;
  logic [8:0]  cfg_width_r;
  logic [2:0]  cfg_kernel_r;
  logic [2:0]  cfg_stride_r;
  logic [23:0] cfg_zp_r;
  logic [47:0] cfg_mult_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_in_ch_r  <= 11'd1;
      cfg_out_ch_r <= 11'd1;
      cfg_height_r <= 9'd1;
      cfg_width_r  <= 9'd1;
      cfg_kernel_r <= 3'd3;
      cfg_stride_r <= 3'd1;
      cfg_zp_r     <= 24'd0;
      cfg_mult_r   <= 48'h0100_0000_0000;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_IN_CH:  cfg_in_ch_r  <= cfg_data[10:0];
        REG_OUT_CH: cfg_out_ch_r <= cfg_data[10:0];
        REG_HEIGHT: cfg_height_r <= cfg_data[8:0];
        REG_WIDTH:  cfg_width_r  <= cfg_data[8:0];
        REG_KERNEL: cfg_kernel_r <= cfg_data[2:0];
        REG_STRIDE: cfg_stride_r <= cfg_data[2:0];
        REG_ZP:     cfg_zp_r     <= cfg_data[23:0];
        REG_MULT:   cfg_mult_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective geometry: zero acts as one, counts and sizes are capped
  logic [10:0] icn_e;
  logic [10:0] ocn_e;
  logic [8:0]  h_e;
  logic [8:0]  w_e;
  logic [2:0]  k_e;
  logic [2:0]  s_e;

  assign icn_e = (cfg_in_ch_r == 11'd0) ? 11'd1 :
                 ((32'(cfg_in_ch_r) > 32'(MAX_CHANNELS)) ? 11'(MAX_CHANNELS) : cfg_in_ch_r);
  assign ocn_e = (cfg_out_ch_r == 11'd0) ? 11'd1 :
                 ((32'(cfg_out_ch_r) > 32'(MAX_CHANNELS)) ? 11'(MAX_CHANNELS) : cfg_out_ch_r);
  assign h_e   = (cfg_height_r == 9'd0) ? 9'd1 :
                 ((cfg_height_r > 9'd256) ? 9'd256 : cfg_height_r);
  assign w_e   = (cfg_width_r == 9'd0) ? 9'd1 :
                 ((cfg_width_r > 9'd256) ? 9'd256 : cfg_width_r);
  assign k_e   = (cfg_kernel_r == 3'd0) ? 3'd1 : cfg_kernel_r;
  assign s_e   = (cfg_stride_r == 3'd0) ? 3'd1 : cfg_stride_r;

  // latched geometry of the current compute item
  logic [15:0] addr_r;
  logic [10:0] icn_r;
  logic [10:0] ocn_r;
  logic [8:0]  h_r;
  logic [8:0]  w_r;
  logic [2:0]  k_r;
  logic [2:0]  s_r;
  logic [1:0]  pad_r;
  logic [5:0]  kk_r;
  logic [16:0] hw_r;
  logic [8:0]  ohn_r;
  logic [8:0]  own_r;
  logic [17:0] t1_r;
  logic [28:0] total_r;
  logic [8:0]  ow_r;
  logic [8:0]  oh_r;
  logic [10:0] oc_r;
  logic signed [11:0] bh_r;
  logic signed [11:0] bw_r;
  logic [21:0] ocic_r;
  logic signed [28:0] rowb_r;
  logic signed [BIAS_W-1:0] bias_lat_r;

  // tap walker
  logic [10:0] ic_r;
  logic [2:0]  kh_r;
  logic [2:0]  kw_r;
  logic signed [11:0] ih_r;
  logic signed [11:0] iw_r;
  logic [27:0] plane_r;
  logic signed [28:0] row_r;
  logic [28:0] widx_r;

  // multiply/accumulate pipeline
  logic        vld1_r;
  logic        pin1_r;
  logic        win1_r;
  logic        vld2_r;
  logic signed [17:0] prod_r;
  logic [ACC_W-1:0]   acc_r;

  // result staging and output register
  logic       res_err_r;
  logic [7:0] res_pix_r;
  logic       out_valid_r;
  logic [7:0] out_pixel_r;
  logic       out_err_r;

  // divider
  logic        div_start;
  logic [15:0] div_dvd;
  logic [15:0] div_dvs;
  logic        div_done;
  logic [15:0] div_q;
  logic [15:0] div_rem;

  // store access
  rd_req_t     rd;
  logic        ld_en;
  logic [7:0]  pix_rd_data;
  logic [7:0]  wt_rd_data;
  logic [BIAS_W-1:0] bias_rd_data;
  logic [31:0] pix_addr32;
  logic [31:0] wt_addr32;
  logic [31:0] bias_addr32;

  // requantizer
  logic       rq_start;
  logic       rq_done;
  logic [7:0] rq_pixel;

  logic in_fire;
  logic out_fire;
  logic out_free;

  assign in_ch.ready = (state_r == S_IDLE) && !out_pend_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid_r && out_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign ld_en       = in_fire && (mode_t'(in_ch.mode) != MODE_COMPUTE);

  // tap address generation
  logic signed [28:0] pidx;
  logic        inb;
  logic        p_in;
  logic        w_in;
  logic        last_tap;

  assign pidx = $signed({1'b0, plane_r}) + row_r + 29'(iw_r);
  assign inb  = (ih_r >= 12'sd0) && (ih_r < $signed({3'b0, h_r})) &&
                (iw_r >= 12'sd0) && (iw_r < $signed({3'b0, w_r}));
  assign pix_addr32 = 32'($unsigned(pidx));
  assign wt_addr32  = 32'(widx_r);
  assign bias_addr32 = 32'(oc_r);
  // taps whose index lies beyond a store read as zero
  assign p_in = pix_addr32 < 32'(INPUT_DEPTH);
  assign w_in = wt_addr32 < 32'(WEIGHT_DEPTH);
  assign last_tap = (kw_r == k_r - 3'd1) && (kh_r == k_r - 3'd1) && (ic_r == icn_r - 11'd1);

  assign rd.pix_en  = (state_r == S_MAC) && inb && p_in;
  assign rd.wt_en   = (state_r == S_MAC) && inb && w_in;
  assign rd.bias_en = (state_r == S_PRE1);

  assign rq_start = (state_r == S_DRAIN) && !vld1_r && !vld2_r;

  // divider operand selection: output height, output width, then index decode
  always_comb begin
    div_start = 1'b0;
    div_dvd   = 16'd0;
    div_dvs   = 16'd1;
    case (state_r)
      S_GEOM: begin
        div_start = 1'b1;
        div_dvd   = 16'(h_e - 9'(k_e[0]));
        div_dvs   = 16'(s_e);
      end
      S_DIVH: begin
        div_start = div_done;
        div_dvd   = 16'(w_r - 9'(k_r[0]));
        div_dvs   = 16'(s_r);
      end
      S_CHK: begin
        div_start = 29'(addr_r) < total_r;
        div_dvd   = addr_r;
        div_dvs   = 16'(own_r);
      end
      S_DIV1: begin
        div_start = div_done;
        div_dvd   = div_q;
        div_dvs   = 16'(ohn_r);
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      out_pend_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (out_pend_r) begin
            if (out_free) out_pend_r <= 1'b0;
          end else if (in_fire && (mode_t'(in_ch.mode) == MODE_COMPUTE)) begin
            state_r <= S_GEOM;
          end
        end
        S_GEOM: state_r <= S_DIVH;
        S_DIVH: if (div_done) state_r <= S_DIVW;
        S_DIVW: if (div_done) state_r <= S_TOT1;
        S_TOT1: state_r <= S_TOT2;
        S_TOT2: state_r <= S_CHK;
        S_CHK: begin
          if (29'(addr_r) < total_r) begin
            state_r <= S_DIV1;
          end else begin
            state_r    <= S_IDLE;
            out_pend_r <= 1'b1;
          end
        end
        S_DIV1: if (div_done) state_r <= S_DIV2;
        S_DIV2: if (div_done) state_r <= S_PRE1;
        S_PRE1: state_r <= S_PRE2;
        S_PRE2: state_r <= S_MAC;
        S_MAC:  if (last_tap) state_r <= S_DRAIN;
        S_DRAIN: if (rq_start) state_r <= S_RQ;
        S_RQ: begin
          if (rq_done) begin
            state_r    <= S_IDLE;
            out_pend_r <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // geometry and walker datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (in_fire) addr_r <= in_ch.address;
      S_GEOM: begin
        icn_r <= icn_e;
        ocn_r <= ocn_e;
        h_r   <= h_e;
        w_r   <= w_e;
        k_r   <= k_e;
        s_r   <= s_e;
        pad_r <= k_e[2:1];
        kk_r  <= 6'(k_e) * 6'(k_e);
        hw_r  <= 17'(h_e) * 17'(w_e);
      end
      S_DIVH: if (div_done) ohn_r <= div_q[8:0] + 9'd1;
      S_DIVW: if (div_done) own_r <= div_q[8:0] + 9'd1;
      S_TOT1: t1_r    <= 18'(ohn_r) * 18'(own_r);
      S_TOT2: total_r <= 29'(t1_r) * 29'(ocn_r);
      S_CHK: begin
        res_err_r <= 1'b1;
        res_pix_r <= 8'd0;
      end
      S_DIV1: if (div_done) ow_r <= div_rem[8:0];
      S_DIV2: begin
        if (div_done) begin
          oh_r <= div_rem[8:0];
          oc_r <= div_q[10:0];
        end
      end
      S_PRE1: begin
        bh_r   <= $signed(12'(oh_r) * 12'(s_r)) - $signed(12'(pad_r));
        bw_r   <= $signed(12'(ow_r) * 12'(s_r)) - $signed(12'(pad_r));
        ocic_r <= 22'(oc_r) * 22'(icn_r);
      end
      S_PRE2: begin
        rowb_r     <= 29'(bh_r) * $signed(29'(w_r));
        row_r      <= 29'(bh_r) * $signed(29'(w_r));
        widx_r     <= 29'(ocic_r) * 29'(kk_r);
        bias_lat_r <= $signed(bias_rd_data);
        ic_r       <= '0;
        kh_r       <= '0;
        kw_r       <= '0;
        ih_r       <= bh_r;
        iw_r       <= bw_r;
        plane_r    <= '0;
      end
      S_MAC: begin
        // weights are laid out in loop order, so the index just counts
        widx_r <= widx_r + 29'd1;
        if (kw_r == k_r - 3'd1) begin
          kw_r <= '0;
          iw_r <= bw_r;
          if (kh_r == k_r - 3'd1) begin
            kh_r    <= '0;
            ih_r    <= bh_r;
            row_r   <= rowb_r;
            ic_r    <= ic_r + 11'd1;
            plane_r <= plane_r + 28'(hw_r);
          end else begin
            kh_r  <= kh_r + 3'd1;
            ih_r  <= ih_r + 12'sd1;
            row_r <= row_r + $signed(29'(w_r));
          end
        end else begin
          kw_r <= kw_r + 3'd1;
          iw_r <= iw_r + 12'sd1;
        end
      end
      S_RQ: begin
        if (rq_done) begin
          res_err_r <= 1'b0;
          res_pix_r <= rq_pixel;
        end
      end
      default: ;
    endcase
  end

  // multiply/accumulate: read data arrives in the cycle after the tap issues
  logic [7:0]         pix_v;
  logic signed [7:0]  wt_v;
  logic signed [8:0]  dp;
  logic signed [8:0]  dw;

  assign pix_v = pin1_r ? pix_rd_data : 8'd0;
  assign wt_v  = win1_r ? $signed(wt_rd_data) : 8'sd0;
  assign dp    = $signed({1'b0, pix_v}) - $signed({1'b0, cfg_zp_r[7:0]});
  assign dw    = 9'(wt_v) - 9'($signed(cfg_zp_r[15:8]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= (state_r == S_MAC) && inb;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    pin1_r <= p_in;
    win1_r <= w_in;
    prod_r <= 18'(dp) * 18'(dw);
    if (state_r == S_PRE2) begin
      acc_r <= '0;
    end else if (vld2_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_pend_r && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_pend_r && out_free) begin
      out_pixel_r <= res_pix_r;
      out_err_r   <= res_err_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_pixel   = out_pixel_r;
  assign out_ch.index_error = out_err_r;

  qcr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_rem)
  );

  qcr_store #(
    .INPUT_DEPTH  (INPUT_DEPTH),
    .WEIGHT_DEPTH (WEIGHT_DEPTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_store (
    .clk          (clk),
    .ld_en        (ld_en),
    .ld_mode      (in_ch.mode),
    .ld_addr      (in_ch.address),
    .ld_pixel     (in_ch.pixel_value),
    .ld_weight    (in_ch.weight_value),
    .ld_bias      (in_ch.bias_value),
    .rd           (rd),
    .pix_rd_addr  (pix_addr32),
    .wt_rd_addr   (wt_addr32),
    .bias_rd_addr (bias_addr32),
    .pix_rd_data  (pix_rd_data),
    .wt_rd_data   (wt_rd_data),
    .bias_rd_data (bias_rd_data)
  );

  qcr_requant #(
    .MULT_FRAC_BITS (MULT_FRAC_BITS)
  ) u_requant (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rq_start),
    .acc   (acc_r),
    .bias  (bias_lat_r),
    .mult  (cfg_mult_r),
    .zout  (cfg_zp_r[23:16]),
    .done  (rq_done),
    .pixel (rq_pixel)
  );

  // divider results only land in a state that waits for them
  `ASSERT_IMPLY(a_div_done_state, clk, rst_n, div_done,
    (state_r == S_DIVH) || (state_r == S_DIVW) || (state_r == S_DIV1) || (state_r == S_DIV2))
  // requantizer finishes only while the sequencer waits on it
  `ASSERT_IMPLY(a_rq_done_state, clk, rst_n, rq_done, state_r == S_RQ)
  // accumulator pipeline is fed by the tap walker alone
  `ASSERT_IMPLY(a_pipe_source, clk, rst_n, vld1_r, $past(state_r == S_MAC))
  // a staged result moves into a free output register on the next edge
  `ASSERT_NEXT(a_out_load, clk, rst_n, out_pend_r && out_free, out_valid_r && !out_pend_r)

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import qcr_pkg::*;

  // per-phase register setting
  typedef struct {
    int unsigned ic, oc, ht, wd, ks, st;
    bit [23:0]   zp;
    bit [47:0]   mult;
  } conv_cfg_t;

  typedef struct {
    bit [7:0] pixel;
    bit       err;
  } conv_out_t;

  // shadow stores, register copy and queue of expected output pixels
  class conv_tracker;
    bit [7:0]   pix_mem[65536];
    bit [7:0]   wt_mem[65536];
    bit [63:0]  bias_mem[1024];
    conv_cfg_t  cfg;
    conv_out_t  pending_pixels[$];
    int         errors;

    function new();
      cfg = '{1, 1, 1, 1, 3, 1, 24'd0, 48'd1 << 40};
    endfunction

    function int unsigned eff(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    // effective geometry: channels, sizes, kernel, stride, output size
    function void geometry(output int unsigned icn, ocn, h, w, k, s, ohn, own);
      icn = eff(cfg.ic, 1024);
      ocn = eff(cfg.oc, 1024);
      h   = eff(cfg.ht, 256);
      w   = eff(cfg.wd, 256);
      k   = eff(cfg.ks, 7);
      s   = eff(cfg.st, 7);
      ohn = (h + 2 * (k / 2) - k) / s + 1;
      own = (w + 2 * (k / 2) - k) / s + 1;
    endfunction

    function conv_out_t conv_pixel(bit [15:0] addr);
      int unsigned icn, ocn, h, w, k, s, ohn, own, pad, oc, oh, ow, pidx, widx;
      int ih, iw, zin, zwt, zout, pv, wv;
      bit [31:0] acc;
      logic signed [127:0] a, m, b, v;
      logic [127:0] rq;
      int val;
      conv_out_t r;
      geometry(icn, ocn, h, w, k, s, ohn, own);
      pad = k / 2;
      if (addr >= ocn * ohn * own) begin
        r.pixel = 8'd0;
        r.err = 1'b1;
        return r;
      end
      ow = addr % own;
      oh = (addr / own) % ohn;
      oc = (addr / own) / ohn;
      zin  = cfg.zp[7:0];
      zwt  = $signed(cfg.zp[15:8]);
      zout = cfg.zp[23:16];
      acc = 32'd0;
      for (int unsigned ic = 0; ic < icn; ic++)
        for (int unsigned kh = 0; kh < k; kh++)
          for (int unsigned kw = 0; kw < k; kw++) begin
            ih = int'(oh * s + kh) - int'(pad);
            iw = int'(ow * s + kw) - int'(pad);
            if (ih < 0 || ih >= int'(h) || iw < 0 || iw >= int'(w)) continue;
            pidx = ic * h * w + ih * w + iw;
            widx = ((oc * icn + ic) * k + kh) * k + kw;
            pv = (pidx < 65536) ? int'(pix_mem[pidx]) : 0;
            wv = (widx < 65536) ? int'($signed(wt_mem[widx])) : 0;
            acc += 32'((pv - zin) * (wv - zwt));
          end
      // acc * mult + bias at 2^40 scale, rounded half away from zero
      a = {{96{acc[31]}}, acc};
      m = {80'd0, cfg.mult};
      b = {{64{bias_mem[oc][63]}}, bias_mem[oc]};
      v = a * m + b;
      rq = ((v < 0) ? -v : v) + (128'd1 << 39);
      rq = rq >> 40;
      if (rq > 1024) rq = 1024;
      val = (v < 0) ? -int'(rq) : int'(rq);
      val += zout;
      r.pixel = (val > 255) ? 8'd255 : (val < 0) ? 8'd0 : 8'(val);
      r.err = 1'b0;
      return r;
    endfunction

    function void note_transfer(mode_t md, bit [15:0] ad, bit [7:0] pv, bit [7:0] wv,
                                bit [63:0] bv);
      case (md)
        MODE_PIXEL:   pix_mem[ad] = pv;
        MODE_WEIGHT:  wt_mem[ad] = wv;
        MODE_BIAS:    if (ad < 1024) bias_mem[ad] = bv;
        MODE_COMPUTE: pending_pixels.push_back(conv_pixel(ad));
        default: ;
      endcase
    endfunction

    function void check_pixel(bit [7:0] px, bit err);
      conv_out_t e;
      if (pending_pixels.size() == 0) begin
        $error("unexpected result transfer: out_pixel %0d index_error %0d", px, err);
        errors++;
        return;
      end
      e = pending_pixels.pop_front();
      if (px !== e.pixel) begin
        $error("out_pixel: expected %0d, actual %0d", e.pixel, px);
        errors++;
      end
      if (err !== e.err) begin
        $error("index_error: expected %0d, actual %0d", e.err, err);
        errors++;
      end
    endfunction
  endclass

  localparam int IDLE_LIMIT = 20000;
  localparam int LONG_HOLD  = 2000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  qcr_in_if  in_ch();
  qcr_out_if out_ch();

  quantized_conv2d_requant_top uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  conv_tracker tracker = new();

  int burst_left;
  bit hold_req;
  int hold_cnt;
  int pat_sel;
  int cyc;
  int idle_cnt;

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // result side: random stall patterns, plus one long hold-off on request
  always @(posedge clk) begin
    cyc++;
    if (cyc % 256 == 0) pat_sel = $urandom_range(0, 3);
    if (hold_cnt != 0) begin
      hold_cnt--;
      out_ch.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else begin
      case (pat_sel)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= $urandom_range(0, 1);
        2:       out_ch.ready <= (cyc % 4 != 0);
        default: out_ch.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.check_pixel(out_ch.out_pixel, out_ch.index_error);
  end

  // watchdog: cycles with no transfer at all
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we || !rst_n)
      idle_cnt = 0;
    else
      idle_cnt++;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // offer one item; bursts of random length separated by random gaps
  task automatic push_item(mode_t md, bit [15:0] ad, bit [7:0] pv = 0, bit [7:0] wv = 0,
                           bit [63:0] bv = 0);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= md;
    in_ch.address      <= ad;
    in_ch.pixel_value  <= pv;
    in_ch.weight_value <= wv;
    in_ch.bias_value   <= bv;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_transfer(md, ad, pv, wv, bv);
    burst_left--;
  endtask

  // stop offering and wait until every expected result has arrived
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (tracker.pending_pixels.size() != 0);
  endtask

  task automatic write_regs(conv_cfg_t c);
    bit [47:0] vals[8];
    drain();
    // loads leave nothing to wait for, so give the pipeline time to settle
    repeat (150) @(posedge clk);
    vals = '{48'(c.ic), 48'(c.oc), 48'(c.ht), 48'(c.wd), 48'(c.ks), 48'(c.st),
             48'(c.zp), c.mult};
    for (int r = 0; r < 8; r++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_idx_t'(r);
      cfg_data  <= vals[r];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    tracker.cfg = c;
  endtask

  function automatic bit [63:0] rand_bias();
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    return 64'($signed({$urandom, $urandom}) >>> $urandom_range(14, 24));
  endfunction

  // store sizes needed by the current geometry
  task automatic store_sizes(output int unsigned np, nw, nb, tot);
    int unsigned icn, ocn, h, w, k, s, ohn, own;
    tracker.geometry(icn, ocn, h, w, k, s, ohn, own);
    np  = icn * h * w;
    nw  = ocn * icn * k * k;
    nb  = ocn;
    tot = ocn * ohn * own;
  endtask

  // fill every entry that a compute can read
  task automatic preload();
    int unsigned np, nw, nb, tot;
    store_sizes(np, nw, nb, tot);
    for (int unsigned i = 0; i < np; i++) push_item(MODE_PIXEL, i, $urandom);
    for (int unsigned i = 0; i < nw; i++) push_item(MODE_WEIGHT, i, 0, $urandom);
    for (int unsigned i = 0; i < nb; i++) push_item(MODE_BIAS, i, 0, 0, rand_bias());
  endtask

  // random mix of computes and store rewrites
  task automatic random_items(int n, bit with_hold);
    int unsigned np, nw, nb, tot, sel;
    store_sizes(np, nw, nb, tot);
    for (int i = 0; i < n; i++) begin
      // long hold-off on the result side fills the block up
      if (with_hold && i == 5) hold_req = 1'b1;
      // one pause until everything is back
      if (with_hold && i == 30) drain();
      sel = $urandom_range(0, 99);
      if (sel < 10)
        push_item(MODE_PIXEL, $urandom_range(0, np - 1), $urandom);
      else if (sel < 20)
        push_item(MODE_WEIGHT, $urandom_range(0, nw - 1), 0, $urandom);
      else if (sel < 27)
        push_item(MODE_BIAS, $urandom_range(0, nb - 1), 0, 0, rand_bias());
      else if (sel < 87)
        push_item(MODE_COMPUTE, $urandom_range(0, tot - 1));
      else
        push_item(MODE_COMPUTE, $urandom_range(tot, 65535));
    end
  endtask

  function automatic bit [47:0] rand_mult();
    return (48'd1 << 40) >> $urandom_range(4, 14) | 48'($urandom_range(0, 65535));
  endfunction

  conv_cfg_t phases[$];

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.mode         = MODE_PIXEL;
    in_ch.address      = '0;
    in_ch.pixel_value  = '0;
    in_ch.weight_value = '0;
    in_ch.bias_value   = '0;
    out_ch.ready       = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_IN_CH;
    cfg_data           = '0;
    rst_n              = 1'b0;
    hold_req           = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 1x1 map, 3x3 kernel, only the center tap lands
    write_regs('{1, 1, 1, 1, 3, 1, 24'd0, 48'd1 << 40});
    preload();
    push_item(MODE_PIXEL, 0, 8'd255);
    push_item(MODE_WEIGHT, 4, 0, 8'sd127);
    push_item(MODE_BIAS, 0, 0, 0, 64'd0);
    push_item(MODE_COMPUTE, 0);
    push_item(MODE_WEIGHT, 4, 0, 8'h80);
    push_item(MODE_PIXEL, 0, 8'd0);
    push_item(MODE_COMPUTE, 0);
    // bias extremes saturate both ways
    push_item(MODE_BIAS, 0, 0, 0, 64'h7fff_ffff_ffff_ffff);
    push_item(MODE_COMPUTE, 0);
    push_item(MODE_BIAS, 0, 0, 0, 64'h8000_0000_0000_0000);
    push_item(MODE_COMPUTE, 0);
    push_item(MODE_BIAS, 0, 0, 0, 64'hffff_ffff_ffff_ffff);
    push_item(MODE_COMPUTE, 0);
    // out-of-range output index
    push_item(MODE_COMPUTE, 1);
    push_item(MODE_COMPUTE, 16'hffff);
    // zero points and multiplier extremes
    write_regs('{1, 1, 1, 1, 3, 1, 24'hff80ff, 48'hffff_ffff_ffff});
    push_item(MODE_COMPUTE, 0);
    push_item(MODE_PIXEL, 0, 8'd255);
    push_item(MODE_COMPUTE, 0);
    write_regs('{1, 1, 1, 1, 3, 1, 24'h007f00, 48'd0});
    push_item(MODE_COMPUTE, 0);
    push_item(MODE_BIAS, 0, 0, 0, 64'd1 << 39);
    push_item(MODE_COMPUTE, 0);
    push_item(MODE_BIAS, 0, 0, 0, -(64'd1 << 39));
    push_item(MODE_COMPUTE, 0);

    // random phases: small maps mostly, a few at the register extremes
    phases.push_back('{2, 2, 5, 5, 3, 1, 24'($urandom), rand_mult()});
    phases.push_back('{1, 2, 6, 4, 7, 2, 24'($urandom), rand_mult()});
    // zero in every size register acts as one
    phases.push_back('{0, 0, 0, 0, 0, 0, 24'($urandom), rand_mult()});
    phases.push_back('{1, 2, 7, 5, 5, 3, 24'($urandom), 48'hffff_ffff_ffff});
    phases.push_back('{1, 2, 4, 6, 2, 4, 24'($urandom), rand_mult()});
    phases.push_back('{2, 2, 4, 4, 4, 1, 24'($urandom), 48'd0});
    phases.push_back('{1, 1, 3, 3, 3, 1, 24'hffffff, rand_mult()});
    foreach (phases[p]) begin
      write_regs(phases[p]);
      preload();
      random_items(40, p == 0);
    end

    drain();
    repeat (200) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_pixels.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ----- quantized_conv2d_requant_top.f -----
+incdir+hdl
hdl/qcr_pkg.sv
hdl/qcr_stream_if.sv
hdl/qcr_div.sv
hdl/qcr_store.sv
hdl/qcr_requant.sv
hdl/quantized_conv2d_requant_top.sv
test/tb_top.sv
